// ===== rtl/core/psenc_pkg.sv =====
// ----------------------------------------------------------------------------
// psenc_pkg: shared types and constants of the panel scan encoder
// Command codes, field positions of the stream beats, and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package psenc_pkg;

  // Command codes carried in s_tuser
  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_WRITE     = 2'd1;
  localparam logic [1:0] CMD_SET_LED   = 2'd2;
  localparam logic [1:0] CMD_READ_ENC  = 2'd3;

  // Result kinds carried in m_tuser
  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_ENC  = 1'b1;

  // Fixed geometry
  localparam int MAX_ROWS = 4;
  localparam int DIGIT_W  = 4;

  // Input beat layout (s_tdata)
  localparam int IN_SW_LO    = 0;
  localparam int IN_PHA      = 4;
  localparam int IN_PHB      = 5;
  localparam int IN_DISP_LO  = 6;
  localparam int IN_ROW_LO   = 10;
  localparam int IN_BYTE_LO  = 12;
  localparam int IN_LEDN_LO  = 20;
  localparam int IN_LEDV     = 24;
  localparam int IN_W        = 32;

  // Output beat layout (m_tdata)
  localparam int OUT_W       = 32;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_HI,
    ST_RD_LO,
    ST_CAP,
    ST_PUSH,
    ST_WR_LO,
    ST_ENC
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/psenc_ram.sv =====
// ----------------------------------------------------------------------------
// psenc_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module psenc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/panel_scan_encoder_tick.sv =====
// ----------------------------------------------------------------------------
// panel_scan_encoder_tick: LED panel scanner, key sampler and quadrature counter
// Flow: a tick gives one beat per display; for each display it passes the states
//   RD_HI, RD_LO, CAP and PUSH, reading the display RAM nibble-serially (one
//   4-bit digit per cycle); PUSH waits while the result beat is not taken.
// A display byte write is two nibble writes, high nibble on accept, low in WR_LO.
//   One command is in work at a time.
// Reset: synchronous; clears row counter, encoder state, LED bits and the
//   per-entry valid bits of the display RAM (entries read as zero until written).
// ----------------------------------------------------------------------------
`default_nettype none

module panel_scan_encoder_tick
  import psenc_pkg::*;
#(
  parameter int DISPLAY_COUNT = 4,
  parameter int ROW_COUNT     = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // command beat
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // [3:0] switch_bits, [4] phase_a, [5] phase_b, [9:6] display_index,
  // [11:10] row_index, [19:12] display_byte, [23:20] led_number, [24] led_value
  input  wire logic [IN_W-1:0]   s_tdata,
  // [1:0] command
  input  wire logic [1:0]        s_tuser,
  // result beat
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // [3:0] row_select, [7:4] led_pins, [15:8] serial_byte, [17:16] key_row,
  // [21:18] key_bits, [28:22] encoder_steps
  output logic [OUT_W-1:0]       m_tdata,
  // [0] kind
  output logic [0:0]             m_tuser,
  output logic                   m_tlast
);

  localparam int DW = (DISPLAY_COUNT > 1) ? $clog2(DISPLAY_COUNT) : 1;
  localparam int EW = DW + 2;          // display entry index: {display, row}
  localparam int AW = EW + 1;          // nibble address: {display, row, half}
  localparam int VN = 1 << EW;
  localparam logic [DW-1:0] DISP_LAST = DW'(DISPLAY_COUNT - 1);

  // Input field decode
  logic [1:0] cmd;
  logic [3:0] in_sw;
  logic       in_pha;
  logic       in_phb;
  logic [3:0] in_disp;
  logic [1:0] in_row;
  logic [7:0] in_byte;
  logic [3:0] in_ledn;
  logic       in_ledv;

  assign cmd     = s_tuser;
  assign in_sw   = s_tdata[IN_SW_LO +: 4];
  assign in_pha  = s_tdata[IN_PHA];
  assign in_phb  = s_tdata[IN_PHB];
  assign in_disp = s_tdata[IN_DISP_LO +: 4];
  assign in_row  = s_tdata[IN_ROW_LO +: 2];
  assign in_byte = s_tdata[IN_BYTE_LO +: 8];
  assign in_ledn = s_tdata[IN_LEDN_LO +: 4];
  assign in_ledv = s_tdata[IN_LEDV];

  // State
  state_t           state, state_next;
  logic [1:0]       row_cnt;
  logic [1:0]       key_row;
  logic [3:0]       key_bits;
  logic [1:0]       enc_prev;
  logic [7:0]       enc_accum;
  logic [6:0]       steps;
  logic [3:0]       led_store [MAX_ROWS];
  logic [DW-1:0]    disp_cnt;
  logic [7:0]       sbuf;
  logic [VN-1:0]    vld;
  logic             vld_q;
  logic [EW-1:0]    wr_entry;
  logic [DIGIT_W-1:0] wr_lo;

  // Output register
  logic             o_kind;
  logic [3:0]       o_row_select;
  logic [3:0]       o_led_pins;
  logic [7:0]       o_serial;
  logic [1:0]       o_key_row;
  logic [3:0]       o_key_bits;
  logic [6:0]       o_steps;

  // Handshake and control
  logic accept;
  logic slot_free;
  logic in_range;
  logic out_load;
  logic last_disp;

  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign in_range  = ({1'b0, in_disp} < 5'(DISPLAY_COUNT)) &&
                     ({1'b0, in_row} < 3'(ROW_COUNT));
  assign last_disp = (disp_cnt == DISP_LAST);

  // Row advance and quadrature step
  logic [2:0] row_inc;
  logic [1:0] row_new;
  logic [1:0] q_now;
  logic [1:0] q_diff;

  assign row_inc = {1'b0, row_cnt} + 3'd1;
  assign row_new = (row_inc >= 3'(ROW_COUNT)) ? 2'd0 : row_inc[1:0];
  assign q_now   = {in_pha, in_pha ^ in_phb};
  assign q_diff  = enc_prev - q_now;

  // Display RAM ports: nibble wide, high nibble at half 1
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DIGIT_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;
  logic [EW-1:0]      rd_entry;
  logic [EW-1:0]      in_entry;
  logic [DIGIT_W-1:0] digit;

  assign rd_entry  = {disp_cnt, row_cnt};
  assign in_entry  = {in_disp[DW-1:0], in_row};
  assign ram_raddr = {rd_entry, (state == ST_RD_HI)};
  assign digit     = vld_q ? ram_rdata : '0;

  psenc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (1 << AW)
  ) u_disp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_TICK:     state_next = ST_RD_HI;
            CMD_WRITE:    state_next = in_range ? ST_WR_LO : ST_IDLE;
            CMD_READ_ENC: state_next = ST_ENC;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_RD_HI: state_next = ST_RD_LO;
      ST_RD_LO: state_next = ST_CAP;
      ST_CAP:   state_next = ST_PUSH;
      ST_PUSH: begin
        if (slot_free) begin
          state_next = last_disp ? ST_IDLE : ST_RD_HI;
        end
      end
      ST_WR_LO: state_next = ST_IDLE;
      ST_ENC: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_tready  = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = {wr_entry, 1'b0};
    ram_wdata = wr_lo;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (accept && (cmd == CMD_WRITE) && in_range) begin
          ram_we    = 1'b1;
          ram_waddr = {in_entry, 1'b1};
          ram_wdata = in_byte[7:4];
        end
      end
      ST_WR_LO: ram_we = 1'b1;
      ST_PUSH:  out_load = slot_free;
      ST_ENC:   out_load = slot_free;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_cnt   <= '0;
      enc_prev  <= '0;
      enc_accum <= '0;
      disp_cnt  <= '0;
      vld       <= '0;
      m_tvalid  <= 1'b0;
      for (int i = 0; i < MAX_ROWS; i++) begin
        led_store[i] <= '0;
      end
    end else begin
      state <= state_next;

      // Take the command
      if (accept) begin
        case (cmd)
          CMD_TICK: begin
            key_row  <= row_cnt;
            key_bits <= in_sw;
            row_cnt  <= row_new;
            disp_cnt <= '0;
            if (q_diff[0]) begin
              enc_prev  <= q_now;
              enc_accum <= q_diff[1] ? enc_accum + 8'd1 : enc_accum - 8'd1;
            end
          end
          CMD_WRITE: begin
            wr_entry <= in_entry;
            wr_lo    <= in_byte[3:0];
            if (in_range) begin
              vld[in_entry] <= 1'b1;
            end
          end
          CMD_SET_LED: begin
            led_store[in_ledn[3:2]][in_ledn[1:0]] <= in_ledv;
          end
          CMD_READ_ENC: begin
            steps     <= enc_accum[7:1];
            enc_accum <= {7'd0, enc_accum[0]};
          end
          default: begin
            steps <= steps;
          end
        endcase
      end

      // Track the entry valid bit alongside the registered read
      vld_q <= vld[rd_entry];

      // Shift in one digit per cycle, high nibble first
      if ((state == ST_RD_LO) || (state == ST_CAP)) begin
        sbuf <= {sbuf[3:0], digit};
      end

      // Advance to the next display once its beat is loaded
      if ((state == ST_PUSH) && slot_free && !last_disp) begin
        disp_cnt <= disp_cnt + DW'(1);
      end

      // Output register: load on new beat, drop on take
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_PUSH) begin
        o_kind       <= KIND_SCAN;
        o_row_select <= 4'b0001 << row_cnt;
        o_led_pins   <= led_store[row_cnt];
        o_serial     <= sbuf;
        o_key_row    <= key_row;
        o_key_bits   <= key_bits;
        o_steps      <= '0;
        m_tlast      <= last_disp;
      end else begin
        o_kind       <= KIND_ENC;
        o_row_select <= '0;
        o_led_pins   <= '0;
        o_serial     <= '0;
        o_key_row    <= '0;
        o_key_bits   <= '0;
        o_steps      <= steps;
        m_tlast      <= 1'b1;
      end
    end
  end

  // Pack the result beat
  assign m_tuser = o_kind;
  assign m_tdata = {3'd0, o_steps, o_key_bits, o_key_row, o_serial, o_led_pins, o_row_select};

endmodule

`default_nettype wire

// ===== dv/panel_scan_encoder_tick_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// panel_scan_encoder_tick_test: self-checking bench of the panel scanner
// Drives tick, display write, LED and encoder read commands on the command
// stream and compares every result beat against a shadow copy of the panel
// state: row counter, display bytes, LED bits and the quadrature counter.
// ----------------------------------------------------------------------------

module panel_scan_encoder_tick_test;
  import psenc_pkg::*;

  localparam int DISPLAYS   = 4;
  localparam int ROWS       = 4;
  localparam int LONG_HOLD  = 300;
  localparam int ITEM_GOAL  = 400;
  localparam int LIMIT_NS   = 2_000_000;

  // expected content of one result beat
  typedef struct packed {
    logic       kind;
    logic [3:0] row_select;
    logic [3:0] led_pins;
    logic [7:0] serial_byte;
    logic [1:0] key_row;
    logic [3:0] key_bits;
    logic [6:0] encoder_steps;
    logic       last;
  } panel_beat_t;

  // Shadow of the panel state; predicts the result beats of each command
  class panel_shadow;
    logic [1:0]  row_ptr;
    logic [7:0]  digit_bytes [16][MAX_ROWS];
    logic [3:0]  led_bits [MAX_ROWS];
    logic [1:0]  enc_prev;
    logic [7:0]  enc_count;
    panel_beat_t pending_beats [$];
    int          errors;

    function new();
      row_ptr   = '0;
      enc_prev  = '0;
      enc_count = '0;
      errors    = 0;
      foreach (digit_bytes[d, r]) digit_bytes[d][r] = '0;
      foreach (led_bits[r]) led_bits[r] = '0;
    endfunction

    // Apply one accepted command beat and queue the beats it causes
    function void take_command(logic [1:0] cmd, logic [IN_W-1:0] data);
      logic [1:0]  sampled;
      logic [1:0]  pos;
      logic [1:0]  dlt;
      logic [3:0]  n;
      panel_beat_t b;
      case (cmd)
        CMD_TICK: begin
          sampled = row_ptr;
          row_ptr = (int'(row_ptr) + 1 >= ROWS) ? 2'd0 : row_ptr + 2'd1;
          // Gray to binary, then count odd distances as one quarter step
          pos = data[IN_PHA] ? 2'b11 : 2'b00;
          pos[0] = pos[0] ^ data[IN_PHB];
          dlt = enc_prev - pos;
          if (dlt[0]) begin
            enc_prev  = pos;
            enc_count = dlt[1] ? enc_count + 8'd1 : enc_count - 8'd1;
          end
          for (int k = 0; k < DISPLAYS; k++) begin
            b             = '0;
            b.kind        = KIND_SCAN;
            b.row_select  = 4'd1 << row_ptr;
            b.led_pins    = led_bits[row_ptr];
            b.serial_byte = digit_bytes[k][row_ptr];
            b.key_row     = sampled;
            b.key_bits    = data[IN_SW_LO +: 4];
            b.last        = (k == DISPLAYS - 1);
            pending_beats.push_back(b);
          end
        end
        CMD_WRITE: begin
          if (data[IN_DISP_LO +: 4] < DISPLAYS && data[IN_ROW_LO +: 2] < ROWS)
            digit_bytes[data[IN_DISP_LO +: 4]][data[IN_ROW_LO +: 2]] =
              data[IN_BYTE_LO +: 8];
        end
        CMD_SET_LED: begin
          n = data[IN_LEDN_LO +: 4];
          led_bits[n[3:2]][n[1:0]] = data[IN_LEDV];
        end
        default: begin
          // arithmetic shift right by one keeps the low seven bits of the upper part
          b               = '0;
          b.kind          = KIND_ENC;
          b.encoder_steps = enc_count[7:1];
          b.last          = 1'b1;
          enc_count       = {7'd0, enc_count[0]};
          pending_beats.push_back(b);
        end
      endcase
    endfunction

    function void match(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Compare one accepted result beat with the oldest expected one
    function void check_beat(logic [OUT_W-1:0] tdata, logic [0:0] tuser, logic tlast);
      panel_beat_t e;
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, expected nothing, actual %h/%b",
                 $time, tdata, tuser);
        return;
      end
      e = pending_beats.pop_front();
      match("kind", 8'(e.kind), 8'(tuser[0]));
      match("row_select", 8'(e.row_select), 8'(tdata[3:0]));
      match("led_pins", 8'(e.led_pins), 8'(tdata[7:4]));
      match("serial_byte", e.serial_byte, tdata[15:8]);
      match("key_row", 8'(e.key_row), 8'(tdata[17:16]));
      match("key_bits", 8'(e.key_bits), 8'(tdata[21:18]));
      match("encoder_steps", 8'(e.encoder_steps), 8'(tdata[28:22]));
      match("last", 8'(e.last), 8'(tlast));
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [1:0]      s_tuser = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [0:0]      m_tuser;
  logic            m_tlast;

  panel_shadow shadow = new();
  bit          hold_off_req = 1'b0;
  int          burst_left = 0;
  int          items_done = 0;

  panel_scan_encoder_tick #(
    .DISPLAY_COUNT(DISPLAYS),
    .ROW_COUNT    (ROWS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always #5 clk = ~clk;

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) shadow.check_beat(m_tdata, m_tuser, m_tlast);
  end

  // Receiver: random stall patterns drawn in turn; long hold-off on request
  initial begin : receiver
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 1) == 1);
          2:       m_tready <= (cyc % 5 == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
        cyc++;
        @(posedge clk);
      end
    end
  end

  // Offer one command beat; bursts of random length with gaps between them
  task automatic send_beat(input logic [1:0] cmd, input logic [IN_W-1:0] data);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    shadow.take_command(cmd, data);
    burst_left--;
    // out-of-range display writes do nothing and are not counted
    if (!(cmd == CMD_WRITE &&
          (data[IN_DISP_LO +: 4] >= DISPLAYS || data[IN_ROW_LO +: 2] >= ROWS)))
      items_done++;
  endtask

  task automatic send_tick(input logic [3:0] sw, input logic pa, input logic pb);
    logic [IN_W-1:0] data;
    data = $urandom();
    data[IN_SW_LO +: 4] = sw;
    data[IN_PHA] = pa;
    data[IN_PHB] = pb;
    send_beat(CMD_TICK, data);
  endtask

  task automatic send_write(input logic [3:0] disp, input logic [1:0] row,
                            input logic [7:0] value);
    logic [IN_W-1:0] data;
    data = $urandom();
    data[IN_DISP_LO +: 4] = disp;
    data[IN_ROW_LO +: 2]  = row;
    data[IN_BYTE_LO +: 8] = value;
    send_beat(CMD_WRITE, data);
  endtask

  task automatic send_led(input logic [3:0] num, input logic value);
    logic [IN_W-1:0] data;
    data = $urandom();
    data[IN_LEDN_LO +: 4] = num;
    data[IN_LEDV] = value;
    send_beat(CMD_SET_LED, data);
  endtask

  task automatic send_read();
    send_beat(CMD_READ_ENC, $urandom());
  endtask

  // Tick with phases moved delta quarter steps from the last counted position
  task automatic step_encoder(input int delta);
    logic [1:0] pos;
    pos = shadow.enc_prev + 2'(delta);
    send_tick(4'($urandom_range(0, 15)), pos[1], pos[1] ^ pos[0]);
  endtask

  task automatic spin_encoder(input int steps, input int delta);
    repeat (steps) step_encoder(delta);
    send_read();
  endtask

  // Drop valid and hold until every expected beat has arrived
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (shadow.pending_beats.size() != 0);
  endtask

  initial begin : limit
    #(LIMIT_NS);
    $display("panel_scan_encoder_tick_test: errors");
    $finish;
  end

  initial begin : stimulus
    int  scenario;
    int  dir;
    bit  held;
    bit  paused;
    bit  spun_up;
    bit  spun_down;
    held      = 1'b0;
    paused    = 1'b0;
    spun_up   = 1'b0;
    spun_down = 1'b0;
    dir       = 1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero read, unwritten bytes, store extremes, ignored writes
    send_read();
    send_tick(4'h0, 1'b0, 1'b0);
    send_write(4'd0, 2'd1, 8'hff);
    send_write(4'd3, 2'd2, 8'h80);
    send_write(4'd3, 2'd1, 8'h01);
    send_write(4'd1, 2'd3, 8'h00);
    send_write(4'd4, 2'd1, 8'haa);
    send_write(4'd15, 2'd3, 8'h55);
    send_led(4'd0, 1'b1);
    send_led(4'd15, 1'b1);
    send_led(4'd5, 1'b1);
    send_led(4'd5, 1'b0);
    // forward quarter steps, then a held level and a two-step jump
    send_tick(4'hf, 1'b0, 1'b1);
    send_tick(4'h5, 1'b1, 1'b1);
    send_tick(4'ha, 1'b1, 1'b0);
    send_tick(4'h0, 1'b0, 1'b0);
    send_tick(4'hf, 1'b0, 1'b0);
    send_tick(4'h3, 1'b1, 1'b1);
    send_read();
    // steps back and forth ending in a negative count, then read
    send_tick(4'hc, 1'b1, 1'b0);
    send_tick(4'h9, 1'b0, 1'b0);
    send_tick(4'h6, 1'b0, 1'b1);
    send_tick(4'h1, 1'b0, 1'b0);
    send_tick(4'he, 1'b1, 1'b0);
    send_read();

    // Random sessions
    while (items_done < ITEM_GOAL) begin
      if (!held && items_done >= 80) begin
        held = 1'b1;
        hold_off_req = 1'b1;
      end
      if (!paused && items_done >= 220) begin
        paused = 1'b1;
        wait_drained();
      end
      if (!spun_up && items_done >= 150) begin
        // drive the counter to its largest positive value
        spun_up = 1'b1;
        send_read();
        spin_encoder(127 - int'(shadow.enc_count), 1);
      end
      if (!spun_down && items_done >= 300) begin
        // and to its most negative value
        spun_down = 1'b1;
        send_read();
        spin_encoder(128 + int'(shadow.enc_count), -1);
      end
      scenario = $urandom_range(0, 9);
      if (scenario < 6) begin
        // scan session: fill some bytes, turn the knob, sometimes read it back
        repeat ($urandom_range(0, 4))
          send_write(4'($urandom_range(0, DISPLAYS - 1)), 2'($urandom_range(0, ROWS - 1)),
                     8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1)
          send_led(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 4) == 0) dir = -dir;
          case ($urandom_range(0, 9))
            8:       step_encoder(0);
            9:       step_encoder(2);
            default: step_encoder(dir);
          endcase
        end
        if ($urandom_range(0, 2) != 0) send_read();
      end else if (scenario < 8) begin
        // noise: any command with any field content
        repeat ($urandom_range(1, 6)) send_beat(2'($urandom_range(0, 3)), $urandom());
      end else if (scenario == 8) begin
        // a broken write outside the panel, then a tick
        send_write(4'($urandom_range(DISPLAYS, 15)), 2'($urandom_range(0, 3)),
                   8'($urandom_range(0, 255)));
        send_tick(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        spin_encoder($urandom_range(20, 140), ($urandom_range(0, 1) == 1) ? 1 : -1);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("panel_scan_encoder_tick_test: clean");
    end else begin
      $display("panel_scan_encoder_tick_test: errors");
    end
    $finish;
  end

endmodule
